// ===== rtl/core/clock_page_replacer_assert.svh =====
// Assertion macros for the clock page replacer checker.
`ifndef CLOCK_PAGE_REPLACER_ASSERT_SVH
`define CLOCK_PAGE_REPLACER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock_page_replacer: check failed");

// Next-cycle implication, disabled while reset is low.
`define CPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock_page_replacer: check failed");

`endif

// ===== rtl/core/cpr_pkg.sv =====
// Shared types and constants for the clock page replacer.
`timescale 1ns / 1ps
package cpr_pkg;

    localparam int SCAN_W  = 16;
    localparam int SCAN_WB = 4;

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan;
        logic commit;
        logic write_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_victim;
        logic set_empty;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== rtl/core/cpr_ctrl.sv =====
// Sequencing state machine for the clock page replacer.
`timescale 1ns / 1ps
module cpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cpr_pkg::t_dp_cmd  o_cmd,
    input  cpr_pkg::t_dp_stat i_stat
);
    import cpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_COMMIT,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_OP;
            end
            S_OP: begin
                if (!i_stat.is_victim) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_RESP;
                end else if (i_stat.set_empty) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                o_cmd.write_out = w_out_free;
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.write_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/cpr_datapath.sv =====
// Frame flags, clock hand, victim scan and result register for the replacer.
`timescale 1ns / 1ps
module cpr_datapath #(
    parameter int FRAMES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpr_pkg::t_dp_cmd  i_cmd,
    output cpr_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_opcode,
    input  logic [5:0]        i_frame_index,
    output logic              o_found,
    output logic [5:0]        o_victim_frame,
    output logic              o_frame_is_old,
    output logic [6:0]        o_tracked_count
);
    import cpr_pkg::*;

    localparam int HW     = (FRAMES > 2) ? $clog2(FRAMES) : 1;
    localparam int CW     = $clog2(FRAMES + 1);
    localparam int IW     = (HW > 6) ? HW : 6;
    localparam int NWORDS = (FRAMES + SCAN_W - 1) / SCAN_W;
    localparam int WCW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int AW     = WCW + SCAN_WB;
    localparam int PADW   = NWORDS * SCAN_W;

    // frame flags and pointers
    logic [FRAMES-1:0] r_in_set, r_ref, r_new;
    logic [FRAMES-1:0] n_in_set, n_ref, n_new;
    logic [HW-1:0]     r_hand, n_hand;
    logic [CW-1:0]     r_count, n_count;

    // current transaction
    t_op               r_op;
    logic [5:0]        r_idx;
    logic [HW-1:0]     w_ix;
    logic              w_idx_ok;

    // scan state
    logic [WCW-1:0]    r_word;
    logic              r_ch_hi, r_ch_any, r_is_hi, r_is_any;
    logic [HW-1:0]     r_ch_hi_pos, r_ch_any_pos, r_is_hi_pos, r_first_inset;
    logic              r_found;
    logic [HW-1:0]     r_victim;

    logic [PADW-1:0]   w_cand_pad, w_inset_pad;
    logic [SCAN_W-1:0] w_cw, w_iw, w_hi;
    logic              w_ch_hi, w_ch_any, w_is_hi, w_is_any;
    logic [SCAN_WB-1:0] w_ch_hi_pos, w_ch_any_pos, w_is_hi_pos, w_is_any_pos;
    logic [HW-1:0]     w_victim;
    logic              w_have_cand;

    // result register
    logic              r_o_found, r_o_old;
    logic [5:0]        r_o_victim;
    logic [6:0]        r_o_count;

    assign w_idx_ok = {1'b0, IW'(r_idx)} < (IW + 1)'(FRAMES);
    assign w_ix     = HW'(r_idx);

    assign o_stat.is_victim = (r_op == OP_VICTIM);
    assign o_stat.set_empty = (r_count == '0);
    assign o_stat.scan_last = (r_word == WCW'(NWORDS - 1));

    always_comb begin
        w_cand_pad  = '0;
        w_inset_pad = '0;
        w_cand_pad[FRAMES-1:0]  = r_in_set & ~r_ref;
        w_inset_pad[FRAMES-1:0] = r_in_set;
    end

    assign w_cw = w_cand_pad[r_word*SCAN_W +: SCAN_W];
    assign w_iw = w_inset_pad[r_word*SCAN_W +: SCAN_W];

    always_comb begin
        for (int j = 0; j < SCAN_W; j++) begin
            w_hi[j] = {r_word, SCAN_WB'(j)} >= AW'(r_hand);
        end
    end

    // lowest set bit of this word, over all and at or past the hand
    always_comb begin
        w_ch_hi = 1'b0; w_ch_any = 1'b0; w_is_hi = 1'b0; w_is_any = 1'b0;
        w_ch_hi_pos = '0; w_ch_any_pos = '0; w_is_hi_pos = '0; w_is_any_pos = '0;
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            if (w_cw[j]) begin
                w_ch_any = 1'b1; w_ch_any_pos = SCAN_WB'(j);
                if (w_hi[j]) begin
                    w_ch_hi = 1'b1; w_ch_hi_pos = SCAN_WB'(j);
                end
            end
            if (w_iw[j]) begin
                w_is_any = 1'b1; w_is_any_pos = SCAN_WB'(j);
                if (w_hi[j]) begin
                    w_is_hi = 1'b1; w_is_hi_pos = SCAN_WB'(j);
                end
            end
        end
    end

    assign w_have_cand = r_ch_hi || r_ch_any;

    always_comb begin
        if (r_ch_hi) begin
            w_victim = r_ch_hi_pos;
        end else if (r_ch_any) begin
            w_victim = r_ch_any_pos;
        end else if (r_is_hi) begin
            w_victim = r_is_hi_pos;
        end else begin
            w_victim = r_first_inset;
        end
    end

    always_comb begin
        n_in_set = r_in_set;
        n_ref    = r_ref;
        n_new    = r_new;
        n_hand   = r_hand;
        n_count  = r_count;
        if (i_cmd.apply && w_idx_ok) begin
            case (r_op)
                OP_PIN: begin
                    if (r_in_set[w_ix]) begin
                        n_in_set[w_ix] = 1'b0;
                        n_count        = r_count - CW'(1);
                    end
                end
                OP_UNPIN: begin
                    if (!r_in_set[w_ix]) begin
                        n_in_set[w_ix] = 1'b1;
                        n_ref[w_ix]    = 1'b1;
                        n_new[w_ix]    = 1'b1;
                        n_count        = r_count + CW'(1);
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.commit) begin
            // second chance: passed-over in-set frames lose their reference bit
            for (int i = 0; i < FRAMES; i++) begin
                if (!w_have_cand) begin
                    if (r_in_set[i]) n_ref[i] = 1'b0;
                end else if (w_victim >= r_hand) begin
                    if (r_in_set[i] && HW'(i) >= r_hand && HW'(i) < w_victim)
                        n_ref[i] = 1'b0;
                end else begin
                    if (r_in_set[i] && (HW'(i) >= r_hand || HW'(i) < w_victim))
                        n_ref[i] = 1'b0;
                end
            end
            n_in_set[w_victim] = 1'b0;
            n_new[w_victim]    = 1'b0;
            n_count            = r_count - CW'(1);
            n_hand             = (w_victim == HW'(FRAMES - 1)) ? '0 : w_victim + HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_set <= '0;
            r_ref    <= '0;
            r_new    <= '0;
            r_hand   <= '0;
            r_count  <= '0;
        end else begin
            r_in_set <= n_in_set;
            r_ref    <= n_ref;
            r_new    <= n_new;
            r_hand   <= n_hand;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_QUERY;
            r_word   <= '0;
            r_ch_hi  <= 1'b0;
            r_ch_any <= 1'b0;
            r_is_hi  <= 1'b0;
            r_found  <= 1'b0;
            r_victim <= '0;
        end else if (i_cmd.load) begin
            r_op     <= t_op'(i_opcode);
            r_word   <= '0;
            r_ch_hi  <= 1'b0;
            r_ch_any <= 1'b0;
            r_is_hi  <= 1'b0;
            r_found  <= 1'b0;
            r_victim <= '0;
        end else if (i_cmd.scan) begin
            r_word <= r_word + WCW'(1);
            if (!r_ch_hi && w_ch_hi) begin
                r_ch_hi     <= 1'b1;
                r_ch_hi_pos <= HW'({r_word, w_ch_hi_pos});
            end
            if (!r_ch_any && w_ch_any) begin
                r_ch_any     <= 1'b1;
                r_ch_any_pos <= HW'({r_word, w_ch_any_pos});
            end
            if (!r_is_hi && w_is_hi) begin
                r_is_hi     <= 1'b1;
                r_is_hi_pos <= HW'({r_word, w_is_hi_pos});
            end
        end else if (i_cmd.commit) begin
            r_found  <= 1'b1;
            r_victim <= w_victim;
        end
    end

    // first in-set frame overall, kept from the lowest word that has one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_any <= 1'b0;
        end else if (i_cmd.load) begin
            r_is_any <= 1'b0;
        end else if (i_cmd.scan && !r_is_any && w_is_any) begin
            r_is_any <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && !r_is_any && w_is_any) begin
            r_first_inset <= HW'({r_word, w_is_any_pos});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_frame_index;
        end
        if (i_cmd.write_out) begin
            r_o_found  <= r_found;
            r_o_victim <= 6'(r_victim);
            r_o_old    <= w_idx_ok && !r_new[w_ix];
            r_o_count  <= 7'(r_count);
        end
    end

    assign o_found         = r_o_found;
    assign o_victim_frame  = r_o_victim;
    assign o_frame_is_old  = r_o_old;
    assign o_tracked_count = r_o_count;

endmodule

// ===== rtl/core/clock_page_replacer.sv =====
// Top level of the clock (second-chance) page replacer.
`timescale 1ns / 1ps
// Clock page replacer over FRAMES frames, one transaction at a time with one
// result per transaction. Pin, unpin and query transactions go from the
// operation state straight to the response state. A victim request scans the
// in-set and reference flags 16 frames per cycle, then commits the victim;
// with an empty set it skips the scan. The result sits in an output
// register, so the next transaction is accepted while it waits to be taken.
// Frame indexes are 6 bits wide: indexes at or above FRAMES leave the state
// alone and report frame_is_old as 0.
module clock_page_replacer #(
    parameter int FRAMES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  logic [5:0] i_frame_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_found,
    output logic [5:0] o_victim_frame,
    output logic       o_frame_is_old,
    output logic [6:0] o_tracked_count
);
    import cpr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    cpr_datapath #(
        .FRAMES(FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_opcode        (i_opcode),
        .i_frame_index   (i_frame_index),
        .o_found         (o_found),
        .o_victim_frame  (o_victim_frame),
        .o_frame_is_old  (o_frame_is_old),
        .o_tracked_count (o_tracked_count)
    );

endmodule

// ===== rtl/core/cpr_checker.sv =====
// Port-level checks for the clock page replacer, bound to the top level.
`timescale 1ns / 1ps
`include "clock_page_replacer_assert.svh"
module cpr_checker #(
    parameter int FRAMES = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_opcode,
    input logic [5:0] i_frame_index,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_found,
    input logic [5:0] o_victim_frame,
    input logic       o_frame_is_old,
    input logic [6:0] o_tracked_count
);

    `CPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_found) && $stable(o_victim_frame) && $stable(o_frame_is_old) && $stable(o_tracked_count))
    `CPR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_opcode) && $stable(i_frame_index))
    `CPR_ASSERT_SAME(a_no_victim_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_victim_frame == 6'd0)
    `CPR_ASSERT_SAME(a_count_range, i_clk, i_rst_n, o_out_valid, o_tracked_count <= FRAMES)
    `CPR_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind clock_page_replacer cpr_checker #(.FRAMES(FRAMES)) u_cpr_checker (.*);
